FILE: sv/tps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg
// shared types, widths and codes of the tick process scheduler
// ----------------------------------------------------------------------------
package tps_pkg;

    // default table depth
    localparam int MAX_ENTRIES_DEF = 16;

    // field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 4;
    localparam int BURST_W    = 16;
    localparam int ARR_W      = 16;
    localparam int PRIO_W     = 8;
    localparam int TIME_W     = 16;
    localparam int WAIT_W     = 16;
    localparam int KEY_W      = 16;
    localparam int POLICY_W   = 2;
    localparam int PCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // process word layout: remaining, arrival, priority
    localparam int PROC_W   = BURST_W + ARR_W + PRIO_W;
    localparam int PRIO_LO  = 0;
    localparam int ARR_LO   = PRIO_W;
    localparam int REM_LO   = PRIO_W + ARR_W;

    // saturation limits
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // selection keys
    localparam logic [POLICY_W-1:0] KEY_REMAIN   = 2'd0;
    localparam logic [POLICY_W-1:0] KEY_ARRIVAL  = 2'd1;
    localparam logic [POLICY_W-1:0] KEY_PRIORITY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PCOUNT  = 2'd2;

    // configuration reset values
    localparam logic [POLICY_W-1:0] POLICY_RST  = KEY_ARRIVAL;
    localparam logic                PREEMPT_RST = 1'b1;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RST  = '0;

    typedef struct packed {
        logic [POLICY_W-1:0] policy_key;
        logic                preempt_enable;
        logic [PCOUNT_W-1:0] process_count;
    } t_cfg;

    typedef struct packed {
        logic              ran_valid;
        logic [IDX_W-1:0]  ran_index;
        logic              ran_finished;
        logic [TIME_W-1:0] tick_count;
        logic [WAIT_W-1:0] waited_ticks;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_PICK,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

FILE: sv/tps_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_in_if
// command channel: one load, tick or read transaction per handshake
// ----------------------------------------------------------------------------
interface tps_in_if import tps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [IDX_W-1:0]   entry_index;
    logic [BURST_W-1:0] burst_length;
    logic [ARR_W-1:0]   arrival_tick;
    logic [PRIO_W-1:0]  priority_level;

    modport source (
        output valid, opcode, entry_index, burst_length, arrival_tick, priority_level,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, burst_length, arrival_tick, priority_level,
        output ready
    );
endinterface

FILE: sv/tps_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_out_if
// result channel: one result transaction per command
// ----------------------------------------------------------------------------
interface tps_out_if import tps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ran_valid;
    logic [IDX_W-1:0]  ran_index;
    logic              ran_finished;
    logic [TIME_W-1:0] tick_count;
    logic [WAIT_W-1:0] waited_ticks;

    modport source (
        output valid, ran_valid, ran_index, ran_finished, tick_count, waited_ticks,
        input  ready
    );

    modport sink (
        input  valid, ran_valid, ran_index, ran_finished, tick_count, waited_ticks,
        output ready
    );
endinterface

FILE: sv/tps_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_store
// process table and waiting counts, each a one-write one-read memory
// ----------------------------------------------------------------------------
module tps_store import tps_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int IW = $clog2(MAX_ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_proc_we,
    input  logic [IW-1:0]     i_proc_waddr,
    input  logic [PROC_W-1:0] i_proc_wdata,
    input  logic [IW-1:0]     i_proc_raddr,
    output logic [PROC_W-1:0] o_proc_rdata,
    input  logic              i_wait_we,
    input  logic [IW-1:0]     i_wait_waddr,
    input  logic [WAIT_W-1:0] i_wait_wdata,
    input  logic [IW-1:0]     i_wait_raddr,
    output logic [WAIT_W-1:0] o_wait_rdata
);

    logic [PROC_W-1:0] r_proc_mem [MAX_ENTRIES];
    logic [WAIT_W-1:0] r_wait_mem [MAX_ENTRIES];
    logic [PROC_W-1:0] r_proc_rdata;
    logic [WAIT_W-1:0] r_wait_rdata;

    // process table: write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_proc_we) begin
            r_proc_mem[i_proc_waddr] <= i_proc_wdata;
        end
        r_proc_rdata <= r_proc_mem[i_proc_raddr];
    end

    // waiting counts: write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_wait_we) begin
            r_wait_mem[i_wait_waddr] <= i_wait_wdata;
        end
        r_wait_rdata <= r_wait_mem[i_wait_raddr];
    end

    assign o_proc_rdata = r_proc_rdata;
    assign o_wait_rdata = r_wait_rdata;

endmodule

FILE: sv/tps_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_seq
// command sequencer: load, read, and the one or two table passes of a tick
// ----------------------------------------------------------------------------
module tps_seq import tps_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int IW = $clog2(MAX_ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    // command transaction
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [BURST_W-1:0] i_burst_length,
    input  logic [ARR_W-1:0]   i_arrival_tick,
    input  logic [PRIO_W-1:0]  i_priority_level,
    // memory ports
    output logic               o_proc_we,
    output logic [IW-1:0]      o_proc_waddr,
    output logic [PROC_W-1:0]  o_proc_wdata,
    output logic [IW-1:0]      o_proc_raddr,
    input  logic [PROC_W-1:0]  i_proc_rdata,
    output logic               o_wait_we,
    output logic [IW-1:0]      o_wait_waddr,
    output logic [WAIT_W-1:0]  o_wait_wdata,
    output logic [IW-1:0]      o_wait_raddr,
    input  logic [WAIT_W-1:0]  i_wait_rdata,
    // result hand-off
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = (CW > PCOUNT_W) ? CW : PCOUNT_W;
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    t_state r_state, n_state;

    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_rd_vld, n_rd_vld;
    logic [IW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_idx_ok, n_idx_ok;
    logic [MAX_ENTRIES-1:0] r_ready, n_ready;
    logic [MAX_ENTRIES-1:0] r_done, n_done;
    logic [TIME_W-1:0]      r_time, n_time;
    logic [IW-1:0]          r_held_idx, n_held_idx;
    logic                   r_held_vld, n_held_vld;
    logic                   r_held_ok, n_held_ok;
    logic [PROC_W-1:0]      r_held_word, n_held_word;
    logic                   r_found, n_found;
    logic [IW-1:0]          r_best_idx, n_best_idx;
    logic [KEY_W-1:0]       r_best_key, n_best_key;
    logic [PROC_W-1:0]      r_best_word, n_best_word;
    logic [IW-1:0]          r_pick_idx, n_pick_idx;
    logic                   r_ran_valid, n_ran_valid;
    logic                   r_ran_finished, n_ran_finished;
    logic [WAIT_W-1:0]      r_waited, n_waited;

    logic [PW-1:0]     cnt_ext;
    logic [CW-1:0]     n_use;
    logic              accept;
    logic              idx_ok;
    logic [IW-1:0]     idx_addr;
    logic              issue;
    logic              pass_end;
    logic [TIME_W-1:0] time_inc;
    logic [ARR_W-1:0]  rd_arrival;
    logic              rd_ready;
    logic              rd_runnable;
    logic [KEY_W-1:0]  rd_key;
    logic              keep_held;
    logic [IW-1:0]     pick_idx;
    logic [PROC_W-1:0] pick_word;
    logic [BURST_W-1:0] pick_rem;
    logic              pick_fin;

    // entries scanned by a tick
    assign cnt_ext = PW'(i_cfg.process_count);
    assign n_use   = (cnt_ext > PW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cnt_ext);

    // addressed entry of a load or read
    assign idx_ok   = XW'(i_entry_index) < XW'(MAX_ENTRIES);
    assign idx_addr = IW'(i_entry_index);

    assign accept   = (r_state == S_IDLE) && i_cmd_valid;
    assign issue    = r_cnt < n_use;
    assign pass_end = !issue && !r_rd_vld;
    assign time_inc = (r_time != TIME_MAX) ? r_time + 1'b1 : r_time;

    // entry coming out of the process table during the scan
    assign rd_arrival  = i_proc_rdata[ARR_LO +: ARR_W];
    assign rd_ready    = r_ready[r_rd_idx] || (rd_arrival == r_time);
    assign rd_runnable = rd_ready && !r_done[r_rd_idx];

    always_comb begin
        case (i_cfg.policy_key)
            KEY_REMAIN:   rd_key = i_proc_rdata[REM_LO +: BURST_W];
            KEY_PRIORITY: rd_key = KEY_W'(i_proc_rdata[PRIO_LO +: PRIO_W]);
            default:      rd_key = rd_arrival;
        endcase
    end

    // choice of the entry that runs
    assign keep_held = !i_cfg.preempt_enable && r_held_vld && r_held_ok;
    assign pick_idx  = keep_held ? r_held_idx : r_best_idx;
    assign pick_word = keep_held ? r_held_word : r_best_word;
    assign pick_rem  = pick_word[REM_LO +: BURST_W];
    assign pick_fin  = pick_rem <= BURST_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_opcode)
                        OP_TICK: n_state = S_SCAN;
                        OP_READ: n_state = S_READ;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_READ: n_state = S_DONE;
            S_SCAN: begin
                if (pass_end) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (keep_held || r_found) begin
                    n_state = S_UPDATE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UPDATE: begin
                if (pass_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_cnt          = r_cnt;
        n_rd_vld       = 1'b0;
        n_rd_idx       = r_rd_idx;
        n_idx_ok       = r_idx_ok;
        n_ready        = r_ready;
        n_done         = r_done;
        n_time         = r_time;
        n_held_idx     = r_held_idx;
        n_held_vld     = r_held_vld;
        n_held_ok      = r_held_ok;
        n_held_word    = r_held_word;
        n_found        = r_found;
        n_best_idx     = r_best_idx;
        n_best_key     = r_best_key;
        n_best_word    = r_best_word;
        n_pick_idx     = r_pick_idx;
        n_ran_valid    = r_ran_valid;
        n_ran_finished = r_ran_finished;
        n_waited       = r_waited;
        o_proc_we      = 1'b0;
        o_proc_waddr   = idx_addr;
        o_proc_wdata   = {i_burst_length, i_arrival_tick, i_priority_level};
        o_proc_raddr   = r_cnt[IW-1:0];
        o_wait_we      = 1'b0;
        o_wait_waddr   = idx_addr;
        o_wait_wdata   = '0;
        o_wait_raddr   = r_cnt[IW-1:0];
        case (r_state)
            S_IDLE: begin
                o_wait_raddr = idx_addr;
                if (accept) begin
                    n_ran_valid    = 1'b0;
                    n_ran_finished = 1'b0;
                    n_waited       = '0;
                    n_idx_ok       = idx_ok;
                    n_cnt          = '0;
                    n_found        = 1'b0;
                    n_held_ok      = 1'b0;
                    // load writes the entry and sets its flags at once
                    if (i_opcode == OP_LOAD && idx_ok) begin
                        o_proc_we          = 1'b1;
                        o_wait_we          = 1'b1;
                        n_ready[idx_addr]  = 1'b0;
                        n_done[idx_addr]   = (i_burst_length == '0);
                        if (r_held_vld && r_held_idx == idx_addr) begin
                            n_held_vld = 1'b0;
                        end
                    end
                end
            end
            S_READ: begin
                n_waited = r_idx_ok ? i_wait_rdata : '0;
            end
            S_SCAN: begin
                // issue the next table read
                if (issue) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_cnt[IW-1:0];
                    n_cnt    = CW'(r_cnt + 1'b1);
                end
                // mark arrivals and keep the running minimum
                if (r_rd_vld) begin
                    n_ready[r_rd_idx] = rd_ready;
                    if (rd_runnable && (!r_found || rd_key < r_best_key)) begin
                        n_found     = 1'b1;
                        n_best_idx  = r_rd_idx;
                        n_best_key  = rd_key;
                        n_best_word = i_proc_rdata;
                    end
                    if (r_rd_idx == r_held_idx) begin
                        n_held_ok   = rd_runnable;
                        n_held_word = i_proc_rdata;
                    end
                end
            end
            S_PICK: begin
                n_cnt = '0;
                if (keep_held || r_found) begin
                    // run the picked entry for one tick
                    o_proc_we    = 1'b1;
                    o_proc_waddr = pick_idx;
                    o_proc_wdata = {pick_fin ? BURST_W'(0) : BURST_W'(pick_rem - 1'b1),
                                    pick_word[REM_LO-1:0]};
                    n_pick_idx     = pick_idx;
                    n_ran_valid    = 1'b1;
                    n_ran_finished = pick_fin;
                    if (pick_fin) begin
                        n_done[pick_idx] = 1'b1;
                        n_held_vld       = 1'b0;
                    end else begin
                        n_held_vld = 1'b1;
                        n_held_idx = pick_idx;
                    end
                end else begin
                    n_held_vld = 1'b0;
                    n_time     = time_inc;
                end
            end
            S_UPDATE: begin
                if (issue) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_cnt[IW-1:0];
                    n_cnt    = CW'(r_cnt + 1'b1);
                end
                // every other runnable entry waits one tick
                o_wait_waddr = r_rd_idx;
                o_wait_wdata = i_wait_rdata + 1'b1;
                o_wait_we    = r_rd_vld && r_ready[r_rd_idx] && !r_done[r_rd_idx]
                               && (r_rd_idx != r_pick_idx) && (i_wait_rdata != WAIT_MAX);
                if (pass_end) begin
                    n_time = time_inc;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // result and handshake outputs
    assign o_cmd_ready         = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_DONE);
    assign o_res.ran_valid     = r_ran_valid;
    assign o_res.ran_index     = r_ran_valid ? IDX_W'(r_pick_idx) : '0;
    assign o_res.ran_finished  = r_ran_finished;
    assign o_res.tick_count    = r_time;
    assign o_res.waited_ticks  = r_waited;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_cnt       <= '0;
            r_ready     <= '0;
            r_done      <= '0;
            r_time      <= '0;
            r_held_idx  <= '0;
            r_held_vld  <= 1'b0;
            r_ran_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_cnt       <= n_cnt;
            r_ready     <= n_ready;
            r_done      <= n_done;
            r_time      <= n_time;
            r_held_idx  <= n_held_idx;
            r_held_vld  <= n_held_vld;
            r_ran_valid <= n_ran_valid;
        end
    end

    // working registers of the current command
    always_ff @(posedge i_clk) begin
        r_rd_idx       <= n_rd_idx;
        r_idx_ok       <= n_idx_ok;
        r_held_ok      <= n_held_ok;
        r_held_word    <= n_held_word;
        r_found        <= n_found;
        r_best_idx     <= n_best_idx;
        r_best_key     <= n_best_key;
        r_best_word    <= n_best_word;
        r_pick_idx     <= n_pick_idx;
        r_ran_finished <= n_ran_finished;
        r_waited       <= n_waited;
    end

endmodule

FILE: sv/tick_process_scheduler.sv
// sequence: load and unknown commands go straight to the result, read via a read state,
//   tick scans the N entries in use, then picks, then if an entry runs makes a second pass
// one command at a time, taken only once the last result is handed on; each pass reads
//   one entry a cycle through the single read port of each memory
// reset: synchronous, clears flags, time, hold and control; tables keep their contents
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_process_scheduler
// tick driven process scheduler with a table of entries; each tick marks
// arrivals, picks the runnable entry with the lowest key and runs it
// ----------------------------------------------------------------------------
module tick_process_scheduler import tps_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tps_in_if.sink                i_cmd,
    tps_out_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_ENTRIES);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    logic              proc_we;
    logic [IW-1:0]     proc_waddr;
    logic [PROC_W-1:0] proc_wdata;
    logic [IW-1:0]     proc_raddr;
    logic [PROC_W-1:0] proc_rdata;
    logic              wait_we;
    logic [IW-1:0]     wait_waddr;
    logic [WAIT_W-1:0] wait_wdata;
    logic [IW-1:0]     wait_raddr;
    logic [WAIT_W-1:0] wait_rdata;
    logic              res_valid;
    logic              res_ready;
    t_result           res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy_key     <= POLICY_RST;
            r_cfg.preempt_enable <= PREEMPT_RST;
            r_cfg.process_count  <= PCOUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POLICY:  r_cfg.policy_key     <= i_cfg_data[POLICY_W-1:0];
                CFG_PREEMPT: r_cfg.preempt_enable <= i_cfg_data[0];
                CFG_PCOUNT:  r_cfg.process_count  <= i_cfg_data[PCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tps_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .i_clk        (i_clk),
        .i_proc_we    (proc_we),
        .i_proc_waddr (proc_waddr),
        .i_proc_wdata (proc_wdata),
        .i_proc_raddr (proc_raddr),
        .o_proc_rdata (proc_rdata),
        .i_wait_we    (wait_we),
        .i_wait_waddr (wait_waddr),
        .i_wait_wdata (wait_wdata),
        .i_wait_raddr (wait_raddr),
        .o_wait_rdata (wait_rdata)
    );

    tps_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd_valid      (i_cmd.valid),
        .o_cmd_ready      (i_cmd.ready),
        .i_opcode         (i_cmd.opcode),
        .i_entry_index    (i_cmd.entry_index),
        .i_burst_length   (i_cmd.burst_length),
        .i_arrival_tick   (i_cmd.arrival_tick),
        .i_priority_level (i_cmd.priority_level),
        .o_proc_we        (proc_we),
        .o_proc_waddr     (proc_waddr),
        .o_proc_wdata     (proc_wdata),
        .o_proc_raddr     (proc_raddr),
        .i_proc_rdata     (proc_rdata),
        .o_wait_we        (wait_we),
        .o_wait_waddr     (wait_waddr),
        .o_wait_wdata     (wait_wdata),
        .o_wait_raddr     (wait_raddr),
        .i_wait_rdata     (wait_rdata),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_res            (res)
    );

    // output register, free when empty or being taken
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    // result transaction
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ran_valid    = r_out.ran_valid;
    assign o_rsp.ran_index    = r_out.ran_index;
    assign o_rsp.ran_finished = r_out.ran_finished;
    assign o_rsp.tick_count   = r_out.tick_count;
    assign o_rsp.waited_ticks = r_out.waited_ticks;

endmodule

FILE: verif/tps_sched_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_sched_check_pkg
// command transaction type and scoreboard for the tick process scheduler
// bench; the scoreboard keeps its own copy of the process table, predicts
// each result as the command is accepted and checks results in order
// ----------------------------------------------------------------------------
package tps_sched_check_pkg;
    import tps_pkg::*;

    // codes outside the defined sets, still reachable through the field widths
    localparam logic [OP_W-1:0]     OP_SPARE  = 2'd3;
    localparam logic [POLICY_W-1:0] KEY_SPARE = 2'd3;

    // one command transaction
    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [IDX_W-1:0]   entry_index;
        logic [BURST_W-1:0] burst_length;
        logic [ARR_W-1:0]   arrival_tick;
        logic [PRIO_W-1:0]  priority_level;
    } t_cmd;

    class sched_scoreboard;
        // process table as the scheduler should hold it
        bit [BURST_W-1:0] remain_tab  [MAX_ENTRIES_DEF];
        bit [ARR_W-1:0]   arrive_tab  [MAX_ENTRIES_DEF];
        bit [PRIO_W-1:0]  prio_tab    [MAX_ENTRIES_DEF];
        bit [WAIT_W-1:0]  waited_tab  [MAX_ENTRIES_DEF];
        bit               ready_f     [MAX_ENTRIES_DEF];
        bit               done_f      [MAX_ENTRIES_DEF];
        bit [TIME_W-1:0]  now;
        int unsigned      held_idx;
        bit               held_ok;

        // control registers
        bit [POLICY_W-1:0] policy;
        bit                preempt;
        bit [PCOUNT_W-1:0] pcount;

        // results still owed by the scheduler, oldest first
        t_result     pending_results [$];
        int unsigned result_seq;
        int unsigned errors;

        function new();
            now        = '0;
            held_idx   = 0;
            held_ok    = 1'b0;
            policy     = POLICY_RST;
            preempt    = PREEMPT_RST;
            pcount     = PCOUNT_RST;
            result_seq = 0;
            errors     = 0;
            foreach (ready_f[i]) begin
                ready_f[i] = 1'b0;
                done_f[i]  = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_POLICY:  policy  = data[POLICY_W-1:0];
                CFG_PREEMPT: preempt = data[0];
                CFG_PCOUNT:  pcount  = data[PCOUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // selection key of one entry under the current policy
        function bit [KEY_W-1:0] key_of(int unsigned i);
            if (policy == KEY_REMAIN)
                return remain_tab[i];
            if (policy == KEY_PRIORITY)
                return {{(KEY_W-PRIO_W){1'b0}}, prio_tab[i]};
            return arrive_tab[i];
        endfunction

        function bit runnable(int unsigned i);
            return ready_f[i] && !done_f[i];
        endfunction

        // advance the table by one command and return its result
        function t_result schedule_step(t_cmd c);
            t_result     r;
            int unsigned n;
            int unsigned pick;
            bit          found;
            bit [KEY_W-1:0] best;

            r     = '0;
            n     = (pcount > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : pcount;
            pick  = 0;
            found = 1'b0;
            best  = '0;
            case (c.opcode)
                OP_LOAD: begin
                    remain_tab[c.entry_index] = c.burst_length;
                    arrive_tab[c.entry_index] = c.arrival_tick;
                    prio_tab[c.entry_index]   = c.priority_level;
                    waited_tab[c.entry_index] = '0;
                    ready_f[c.entry_index]    = 1'b0;
                    done_f[c.entry_index]     = (c.burst_length == '0);
                    if (held_ok && held_idx == c.entry_index)
                        held_ok = 1'b0;
                end
                OP_TICK: begin
                    // arrivals due at the start of this tick
                    for (int unsigned i = 0; i < n; i++)
                        if (!ready_f[i] && arrive_tab[i] == now)
                            ready_f[i] = 1'b1;
                    // keep the held job or select afresh
                    if (!preempt && held_ok && held_idx < n && runnable(held_idx)) begin
                        found = 1'b1;
                        pick  = held_idx;
                    end else begin
                        for (int unsigned i = 0; i < n; i++) begin
                            if (runnable(i) && (!found || key_of(i) < best)) begin
                                found = 1'b1;
                                pick  = i;
                                best  = key_of(i);
                            end
                        end
                    end
                    if (found) begin
                        // everyone else that could run waits a tick
                        for (int unsigned i = 0; i < n; i++)
                            if (i != pick && runnable(i) && waited_tab[i] != WAIT_MAX)
                                waited_tab[i] = waited_tab[i] + 1'b1;
                        if (remain_tab[pick] <= 1) begin
                            remain_tab[pick] = '0;
                            done_f[pick]     = 1'b1;
                            r.ran_finished   = 1'b1;
                            held_ok          = 1'b0;
                        end else begin
                            remain_tab[pick] = remain_tab[pick] - 1'b1;
                            held_ok          = 1'b1;
                            held_idx         = pick;
                        end
                        r.ran_valid = 1'b1;
                        r.ran_index = pick[IDX_W-1:0];
                    end else begin
                        held_ok = 1'b0;
                    end
                    if (now != TIME_MAX)
                        now = now + 1'b1;
                end
                OP_READ: r.waited_ticks = waited_tab[c.entry_index];
                default: ;
            endcase
            r.tick_count = now;
            return r;
        endfunction

        function void note_command(t_cmd c);
            pending_results = {pending_results, schedule_step(c)};
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        // compare one result transaction with the oldest prediction
        task check_result(t_result got);
            t_result want;

            result_seq++;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d arrived with none owed (%h)", result_seq, got));
                return;
            end
            want = pending_results.pop_front();
            if (got.ran_valid !== want.ran_valid)
                report($sformatf("result %0d ran_valid %b, want %b",
                                 result_seq, got.ran_valid, want.ran_valid));
            if (got.ran_index !== want.ran_index)
                report($sformatf("result %0d ran_index %0d, want %0d",
                                 result_seq, got.ran_index, want.ran_index));
            if (got.ran_finished !== want.ran_finished)
                report($sformatf("result %0d ran_finished %b, want %b",
                                 result_seq, got.ran_finished, want.ran_finished));
            if (got.tick_count !== want.tick_count)
                report($sformatf("result %0d tick_count %0d, want %0d",
                                 result_seq, got.tick_count, want.tick_count));
            if (got.waited_ticks !== want.waited_ticks)
                report($sformatf("result %0d waited_ticks %0d, want %0d",
                                 result_seq, got.waited_ticks, want.waited_ticks));
        endtask
    endclass

endpackage

FILE: verif/tb_tick_process_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tick_process_scheduler
// self-checking bench: a directed opening covers field extremes, every
// command and the corner cases, then randomised scheduling episodes run under
// many policy, pre-emption and table-size settings with random gaps on both
// channels and a long result hold-off; every result is checked against the
// scoreboard
// ----------------------------------------------------------------------------
module tb_tick_process_scheduler;
    import tps_pkg::*;
    import tps_sched_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tps_in_if  cmd_if ();
    tps_out_if rsp_if ();

    sched_scoreboard sb = new();

    // gap control shared by both channels
    bit          idle_on;
    int unsigned rsp_hold_cycles;
    t_result     seen_result;

    tick_process_scheduler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_cmd make_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                      logic [BURST_W-1:0] burst, logic [ARR_W-1:0] arr,
                                      logic [PRIO_W-1:0] prio);
        t_cmd c;

        c.opcode         = op;
        c.entry_index    = idx;
        c.burst_length   = burst;
        c.arrival_tick   = arr;
        c.priority_level = prio;
        return c;
    endfunction

    // command with a random payload in every field
    function automatic t_cmd random_cmd(logic [OP_W-1:0] op);
        return make_cmd(op, IDX_W'($urandom_range(0, 15)), BURST_W'($urandom_range(0, 65535)),
                        ARR_W'($urandom_range(0, 65535)), PRIO_W'($urandom_range(0, 255)));
    endfunction

    // job arriving shortly, now and then in the past or far off
    function automatic t_cmd fresh_job(logic [IDX_W-1:0] idx);
        int unsigned        roll;
        int unsigned        arr;
        logic [BURST_W-1:0] burst;

        roll = $urandom_range(0, 99);
        if (roll < 8)
            burst = '0;
        else if (roll < 13)
            burst = BURST_W'($urandom_range(0, 65535));
        else
            burst = BURST_W'($urandom_range(1, 6));
        roll = $urandom_range(0, 99);
        arr  = sb.now + $urandom_range(0, 6);
        if (roll < 8 && sb.now != 0)
            arr = sb.now - 1;
        else if (roll < 12)
            arr = $urandom_range(0, 65535);
        if (arr > TIME_MAX)
            arr = TIME_MAX;
        return make_cmd(OP_LOAD, idx, burst, arr[ARR_W-1:0], PRIO_W'($urandom_range(0, 255)));
    endfunction

    // offer one command and hold it until the scheduler takes it
    task automatic send(t_cmd c);
        int unsigned gap;

        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.opcode         <= c.opcode;
        cmd_if.entry_index    <= c.entry_index;
        cmd_if.burst_length   <= c.burst_length;
        cmd_if.arrival_tick   <= c.arrival_tick;
        cmd_if.priority_level <= c.priority_level;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(c);
    endtask

    // stop offering and let every owed result come back
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one scheduling episode: fill the table in use, then mostly ticks with
    // reads, reloads and stray loads mixed in
    task automatic run_episode(logic [POLICY_W-1:0] policy, bit preempt,
                               logic [PCOUNT_W-1:0] count, int unsigned n_items,
                               int unsigned hold);
        int unsigned span;
        int unsigned roll;

        drain_results();
        write_reg(CFG_POLICY, CFG_DATA_W'(policy));
        write_reg(CFG_PREEMPT, CFG_DATA_W'(preempt));
        write_reg(CFG_PCOUNT, count);
        idle_on = ($urandom_range(0, 3) != 0);
        span    = (count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : ((count == 0) ? 1 : count);
        for (int unsigned k = 0; k < span; k++)
            send(fresh_job(k[IDX_W-1:0]));
        rsp_hold_cycles = hold;
        for (int unsigned k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                send(random_cmd(OP_TICK));
            else if (roll < 78)
                send(random_cmd(OP_READ));
            else if (roll < 92)
                send(fresh_job(IDX_W'($urandom_range(0, span - 1))));
            else
                send(random_cmd(OP_LOAD));
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int unsigned stall;

        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rsp_hold_cycles != 0) begin
                stall           = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
        end
    end

    // check each result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            seen_result = {rsp_if.ran_valid, rsp_if.ran_index, rsp_if.ran_finished,
                           rsp_if.tick_count, rsp_if.waited_ticks};
            sb.check_result(seen_result);
        end
    end

    // run limit
    initial begin : watchdog
        int unsigned cycle_count;

        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_tick_process_scheduler failed");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        cmd_if.valid          <= 1'b0;
        cmd_if.opcode         <= OP_LOAD;
        cmd_if.entry_index    <= '0;
        cmd_if.burst_length   <= '0;
        cmd_if.arrival_tick   <= '0;
        cmd_if.priority_level <= '0;
        idle_on               = 1'b1;
        rsp_hold_cycles       = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle tick with no entries in use
        send(make_cmd(OP_TICK, '1, '1, '1, '1));
        // fill the whole table: extremes, zero burst, arrival already past
        send(make_cmd(OP_LOAD, 4'd0, '1, '1, '1));
        send(make_cmd(OP_LOAD, 4'd1, '0, 16'd1, '0));
        send(make_cmd(OP_LOAD, 4'd2, 16'd2, 16'd1, 8'h80));
        send(make_cmd(OP_LOAD, 4'd3, 16'd1, 16'd2, 8'h01));
        send(make_cmd(OP_LOAD, 4'd4, 16'd3, '0, '0));
        for (int unsigned k = 5; k < 16; k++)
            send(make_cmd(OP_LOAD, k[IDX_W-1:0], BURST_W'(1 + k % 3), ARR_W'(1 + k % 4),
                          PRIO_W'(k * 16)));
        send(make_cmd(OP_READ, 4'd15, '0, '0, '0));
        // unused opcode leaves the table alone
        send(random_cmd(OP_SPARE));
        // unused policy code, no pre-emption: held job runs to completion
        drain_results();
        write_reg(CFG_PCOUNT, 5'd5);
        write_reg(CFG_POLICY, CFG_DATA_W'(KEY_SPARE));
        write_reg(CFG_PREEMPT, CFG_DATA_W'(1'b0));
        repeat (4) send(random_cmd(OP_TICK));
        send(make_cmd(OP_READ, 4'd3, '0, '0, '0));

        // randomised episodes, fixed settings first
        run_episode(KEY_REMAIN,   1'b1, 5'd4,  28, 0);
        run_episode(KEY_ARRIVAL,  1'b0, 5'd16, 28, 0);
        run_episode(KEY_PRIORITY, 1'b1, 5'd8,  28, 250);
        run_episode(KEY_PRIORITY, 1'b0, 5'd5,  28, 0);
        run_episode(KEY_REMAIN,   1'b0, 5'd16, 28, 0);
        run_episode(KEY_SPARE,    1'b1, 5'd31, 28, 0);
        run_episode(KEY_ARRIVAL,  1'b1, 5'd0,  20, 0);
        for (int unsigned e = 0; e < 6; e++)
            run_episode(POLICY_W'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                        PCOUNT_W'($urandom_range(0, 16)), 28, 0);

        // wait out the last results, then the longest tick
        drain_results();
        repeat (2 * MAX_ENTRIES_DEF + 8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_tick_process_scheduler passed");
        else
            $display("tb_tick_process_scheduler failed");
        $finish;
    end

endmodule

FILE: files.f
sv/tps_pkg.sv
sv/tps_in_if.sv
sv/tps_out_if.sv
sv/tps_store.sv
sv/tps_seq.sv
sv/tick_process_scheduler.sv
verif/tps_sched_check_pkg.sv
verif/tb_tick_process_scheduler.sv
